>>> src/contiguous_segment_allocator_macros.svh
// Assertion macros shared by the segment allocator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef CONTIGUOUS_SEGMENT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_SEGMENT_ALLOCATOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CSA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define CSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant checked on every clock edge outside reset.
`define CSA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

>>> src/csa_pkg.sv
// Package of the segment allocator: default sizes, codes and shared types.
// Depends on nothing; used by all RTL modules of the block.
package csa_pkg;

    localparam int MAX_SEGMENTS_DEF   = 64;
    localparam int ADDR_WIDTH_DEF     = 16;
    localparam int TAG_WIDTH_DEF      = 8;
    localparam int TOTAL_MEMORY_RESET = 256;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_WORST = 2'd3
    } fit_t;

    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_FULL      = 3'd2,
        ST_FREED     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_FIT_POLICY   = 1'b0,
        REG_TOTAL_MEMORY = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EDIT
    } state_t;

    // Control of the segment ring: load reinitializes every cell, rotate
    // moves every entry one cell toward the head.
    typedef struct packed {
        logic load;
        logic rotate;
    } ring_ctl_t;

endpackage

>>> src/csa_cell.sv
// One cell of the segment ring: holds one table entry.
// Depends on csa_pkg for the ring control struct.
module csa_cell #(
    parameter int              WIDTH     = 42,
    parameter logic [WIDTH-1:0] RESET_VAL = '0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  csa_pkg::ring_ctl_t ctl,
    input  logic [WIDTH-1:0]   init_val,
    input  logic [WIDTH-1:0]   nbr_in,
    output logic [WIDTH-1:0]   q
);
    import csa_pkg::*;

    logic [WIDTH-1:0] entry_reg;
    logic [WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load)
        begin
            entry_next = init_val;
        end
        else if (ctl.rotate)
        begin
            entry_next = nbr_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= RESET_VAL;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

>>> src/csa_ring.sv
// Ring of segment cells; entries move one cell toward the head per rotation.
// Depends on csa_pkg and csa_cell.
module csa_ring #(
    parameter int               DEPTH      = 64,
    parameter int               WIDTH      = 42,
    parameter logic [WIDTH-1:0] RESET_HEAD = '0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  csa_pkg::ring_ctl_t ctl,
    input  logic [WIDTH-1:0]   init_head,
    input  logic [WIDTH-1:0]   tail_in,
    output logic [WIDTH-1:0]   head_out
);
    import csa_pkg::*;

    logic [WIDTH-1:0] cell_q [DEPTH];

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        localparam logic [WIDTH-1:0] RVAL = (k == 0) ? RESET_HEAD : '0;
        logic [WIDTH-1:0] nbr;
        logic [WIDTH-1:0] ival;

        if (k == DEPTH - 1)
        begin : g_tail
            assign nbr = tail_in;
        end
        else
        begin : g_mid
            assign nbr = cell_q[k+1];
        end

        assign ival = (k == 0) ? init_head : '0;

        csa_cell #(
            .WIDTH     (WIDTH),
            .RESET_VAL (RVAL)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .init_val (ival),
            .nbr_in   (nbr),
            .q        (cell_q[k])
        );
    end

    assign head_out = cell_q[0];

endmodule

>>> src/csa_ctrl.sv
// Sequencer of the segment allocator: scan pass, then rewrite pass, on the ring head.
// Depends on csa_pkg and the assertion macros header.
`include "contiguous_segment_allocator_macros.svh"

module csa_ctrl #(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_WIDTH   = 16,
    parameter int TAG_WIDTH    = 8,
    localparam int EW          = 2 + 2 * ADDR_WIDTH + TAG_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   opcode,
    input  logic [TAG_WIDTH-1:0]   owner_tag,
    input  logic [ADDR_WIDTH-1:0]  request_size,
    input  csa_pkg::fit_t          policy,
    input  logic                   reinit,
    input  logic [EW-1:0]          head,
    output logic [EW-1:0]          tail,
    output logic                   rotate,
    output logic                   busy,
    output logic                   done,
    output csa_pkg::status_t       status,
    output logic [ADDR_WIDTH-1:0]  block_start,
    output logic [ADDR_WIDTH-1:0]  block_size
);
    import csa_pkg::*;

    localparam int A  = ADDR_WIDTH;
    localparam int T  = TAG_WIDTH;
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(2 * MAX_SEGMENTS + 1);
    localparam int KW = $clog2(MAX_SEGMENTS + 1);

    function automatic logic [EW-1:0] pack(input logic hole, input logic [A-1:0] st,
                                           input logic [A-1:0] ln, input logic [T-1:0] ow);
        pack = {1'b1, hole, st, ln, ow};
    endfunction

    // Head entry fields.
    logic          h_valid;
    logic          h_hole;
    logic [A-1:0]  h_start;
    logic [A-1:0]  h_len;
    logic [T-1:0]  h_owner;
    logic [IW-1:0] pos;

    assign h_valid = head[EW-1];
    assign h_hole  = head[EW-2];
    assign h_start = head[EW-3 -: A];
    assign h_len   = head[T+A-1 -: A];
    assign h_owner = head[T-1:0];

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    opcode_t        op_reg;
    logic [T-1:0]   tag_reg;
    logic [A-1:0]   size_reg;
    logic [KW-1:0]  count_reg;
    logic [A-1:0]   nfs_reg;

    assign pos = cnt_reg[IW-1:0];

    // Scan results.
    logic          any_found_reg, after_found_reg, bw_found_reg, from_seen_reg;
    logic [IW-1:0] any_pos_reg, after_pos_reg, bw_pos_reg;
    logic [A-1:0]  any_start_reg, after_start_reg, bw_start_reg;
    logic [A-1:0]  any_len_reg, after_len_reg, bw_len_reg;
    logic          own_found_reg, next_pend_reg, last_seen_reg, last_hole_reg;
    logic          prev_merge_reg, next_merge_reg;
    logic [IW-1:0] own_pos_reg, prev_pos_reg, next_pos_reg, last_pos_reg;
    logic [A-1:0]  own_start_reg, own_len_reg, prev_start_reg, prev_len_reg;
    logic [A-1:0]  next_len_reg, last_start_reg, last_len_reg;

    logic          carry_v_reg, carry_v_next;
    logic [EW-1:0] carry_reg, carry_next;

    logic          done_reg;
    status_t       status_reg;
    logic [A-1:0]  bstart_reg, bsize_reg;

    logic accept;
    logic scan_last;
    logic edit_last;

    assign accept = start && (state_reg == S_IDLE);

    // Pick of the allocation, from the scan results.
    logic          pick_found;
    logic [IW-1:0] pick_pos;
    logic [A-1:0]  pick_start;
    logic [A-1:0]  pick_len;

    always_comb
    begin
        case (policy)
            FIT_FIRST:
            begin
                pick_found = any_found_reg;
                pick_pos   = any_pos_reg;
                pick_start = any_start_reg;
                pick_len   = any_len_reg;
            end
            FIT_NEXT:
            begin
                pick_found = after_found_reg || any_found_reg;
                pick_pos   = after_found_reg ? after_pos_reg   : any_pos_reg;
                pick_start = after_found_reg ? after_start_reg : any_start_reg;
                pick_len   = after_found_reg ? after_len_reg   : any_len_reg;
            end
            default:
            begin
                pick_found = bw_found_reg;
                pick_pos   = bw_pos_reg;
                pick_start = bw_start_reg;
                pick_len   = bw_len_reg;
            end
        endcase
    end

    logic alloc_ok, do_exact, do_split, free_ok, table_full;
    logic [A-1:0] own_merged;

    assign table_full = (count_reg == KW'(MAX_SEGMENTS));
    assign alloc_ok   = (op_reg == OP_ALLOC) && (size_reg != '0) && pick_found;
    assign do_exact   = alloc_ok && (pick_len == size_reg);
    assign do_split   = alloc_ok && (pick_len != size_reg) && !table_full;
    assign free_ok    = (op_reg == OP_FREE) && own_found_reg;
    assign own_merged = own_len_reg + (next_merge_reg ? next_len_reg : '0);

    // Scan-pass predicates on the head entry.
    logic h_fits, h_contains, h_match;

    assign h_fits     = h_valid && h_hole && (h_len >= size_reg);
    assign h_contains = h_valid && (nfs_reg >= h_start) && ((nfs_reg - h_start) < h_len);
    assign h_match    = h_valid && !h_hole && (h_owner == tag_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_EDIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_EDIT:
            begin
                if (edit_last)
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Ring data path: what enters the tail cell in each rotation.
    logic in_pass, hit_pick;

    always_comb
    begin
        tail         = head;
        carry_v_next = carry_v_reg;
        carry_next   = carry_reg;
        in_pass      = (cnt_reg < CW'(MAX_SEGMENTS));
        hit_pick     = in_pass && (pos == pick_pos);
        if (state_reg == S_EDIT)
        begin
            if (do_exact && hit_pick)
            begin
                tail = pack(1'b0, pick_start, pick_len, tag_reg);
            end
            else if (do_split && hit_pick)
            begin
                tail         = pack(1'b0, pick_start, size_reg, tag_reg);
                carry_next   = pack(1'b1, pick_start + size_reg, pick_len - size_reg, '0);
                carry_v_next = 1'b1;
            end
            else if (carry_v_reg)
            begin
                tail = carry_reg;
                if (h_valid)
                begin
                    carry_next = head;
                end
                else
                begin
                    carry_v_next = 1'b0;
                end
            end
            else if (free_ok && in_pass)
            begin
                if (prev_merge_reg && (pos == prev_pos_reg))
                begin
                    tail = pack(1'b1, prev_start_reg, prev_len_reg + own_merged, '0);
                end
                else if (pos == own_pos_reg)
                begin
                    tail = prev_merge_reg ? '0 : pack(1'b1, own_start_reg, own_merged, '0);
                end
                else if (next_merge_reg && (pos == next_pos_reg))
                begin
                    tail = '0;
                end
            end
        end
    end

    assign scan_last = (state_reg == S_SCAN) && (cnt_reg == CW'(MAX_SEGMENTS - 1));
    assign edit_last = (state_reg == S_EDIT) &&
                       (((cnt_reg == CW'(MAX_SEGMENTS - 1)) && !carry_v_next) ||
                        (cnt_reg == CW'(2 * MAX_SEGMENTS)));

    // Outputs toward the ring and the port.
    always_comb
    begin
        rotate = (state_reg != S_IDLE);
        busy   = (state_reg != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            carry_v_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= KW'(1);
            nfs_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            carry_v_reg <= carry_v_next;
            done_reg    <= edit_last;
            if (reinit)
            begin
                count_reg <= KW'(1);
                nfs_reg   <= '0;
            end
            else if (edit_last)
            begin
                if (do_exact || do_split)
                begin
                    nfs_reg <= pick_start;
                end
                if (do_split)
                begin
                    count_reg <= count_reg + KW'(1);
                end
                else if (free_ok)
                begin
                    count_reg <= count_reg - KW'(prev_merge_reg) - KW'(next_merge_reg);
                end
            end
        end
    end

    // Request, scan and result payload.
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (accept)
        begin
            op_reg          <= opcode_t'(opcode);
            tag_reg         <= owner_tag;
            size_reg        <= request_size;
            any_found_reg   <= 1'b0;
            after_found_reg <= 1'b0;
            bw_found_reg    <= 1'b0;
            from_seen_reg   <= 1'b0;
            own_found_reg   <= 1'b0;
            next_pend_reg   <= 1'b0;
            last_seen_reg   <= 1'b0;
            prev_merge_reg  <= 1'b0;
            next_merge_reg  <= 1'b0;
        end
        else if ((state_reg == S_SCAN) && h_valid)
        begin
            if (h_fits && !any_found_reg)
            begin
                any_found_reg <= 1'b1;
                any_pos_reg   <= pos;
                any_start_reg <= h_start;
                any_len_reg   <= h_len;
            end
            if (h_contains)
            begin
                from_seen_reg <= 1'b1;
            end
            if (h_fits && !after_found_reg && (from_seen_reg || h_contains))
            begin
                after_found_reg <= 1'b1;
                after_pos_reg   <= pos;
                after_start_reg <= h_start;
                after_len_reg   <= h_len;
            end
            if (h_fits && (!bw_found_reg ||
                           ((policy == FIT_BEST) && (h_len < bw_len_reg)) ||
                           ((policy == FIT_WORST) && (h_len > bw_len_reg))))
            begin
                bw_found_reg <= 1'b1;
                bw_pos_reg   <= pos;
                bw_start_reg <= h_start;
                bw_len_reg   <= h_len;
            end
            if (h_match && !own_found_reg)
            begin
                own_found_reg  <= 1'b1;
                own_pos_reg    <= pos;
                own_start_reg  <= h_start;
                own_len_reg    <= h_len;
                prev_merge_reg <= last_seen_reg && last_hole_reg;
                prev_pos_reg   <= last_pos_reg;
                prev_start_reg <= last_start_reg;
                prev_len_reg   <= last_len_reg;
                next_pend_reg  <= 1'b1;
            end
            else if (next_pend_reg)
            begin
                next_pend_reg  <= 1'b0;
                next_merge_reg <= h_hole;
                next_pos_reg   <= pos;
                next_len_reg   <= h_len;
            end
            last_seen_reg  <= 1'b1;
            last_hole_reg  <= h_hole;
            last_pos_reg   <= pos;
            last_start_reg <= h_start;
            last_len_reg   <= h_len;
        end

        if (edit_last)
        begin
            bstart_reg <= '0;
            bsize_reg  <= '0;
            if (op_reg == OP_ALLOC)
            begin
                if (!alloc_ok)
                begin
                    status_reg <= ST_NO_FIT;
                end
                else if (do_exact || do_split)
                begin
                    status_reg <= ST_ALLOCATED;
                    bstart_reg <= pick_start;
                    bsize_reg  <= size_reg;
                end
                else
                begin
                    status_reg <= ST_FULL;
                end
            end
            else if (own_found_reg)
            begin
                status_reg <= ST_FREED;
                bstart_reg <= own_start_reg;
                bsize_reg  <= own_len_reg;
            end
            else
            begin
                status_reg <= ST_NOT_FOUND;
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign block_start = bstart_reg;
    assign block_size  = bsize_reg;

    `CSA_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not start a pass")
    `CSA_ASSERT_IMPL(a_done_after_edit, done_reg, $past(state_reg) == S_EDIT,
                     "result strobe outside the end of a rewrite pass")
    `CSA_ASSERT_ALWAYS(a_count_bound, count_reg <= KW'(MAX_SEGMENTS) && count_reg != '0,
                       "segment count out of range")
    `CSA_ASSERT_IMPL(a_carry_in_edit, carry_v_reg, state_reg == S_EDIT,
                     "split remainder pending outside a rewrite pass")

endmodule

>>> src/contiguous_segment_allocator.sv
// Top level of the contiguous segment allocator: configuration registers,
// segment ring and sequencer. Depends on csa_pkg, csa_ring and csa_ctrl.
//
//   channel   | handshake           | payload
//   ----------+---------------------+-------------------------------------
//   request   | start / busy        | opcode, owner_tag, request_size
//   result    | done (one cycle)    | status, block_start, block_size
//   config    | cfg_we              | cfg_index, cfg_data
//
// A request word is taken when start is high and busy is low. It costs two
// full rotations of the segment ring: one to scan the table and one to
// rewrite it. A split whose remainder must travel past the logical end of
// the table keeps the ring rotating until the shifted entries reach a free
// slot. The result word shows on done for one cycle as the last rotation
// completes; the receiver cannot stall it. After reset the table holds one
// hole of 256 units. Writing total_memory reloads the table at once.
module contiguous_segment_allocator #(
    parameter int MAX_SEGMENTS = csa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_WIDTH   = csa_pkg::ADDR_WIDTH_DEF,
    parameter int TAG_WIDTH    = csa_pkg::TAG_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  opcode,
    input  logic [TAG_WIDTH-1:0]  owner_tag,
    input  logic [ADDR_WIDTH-1:0] request_size,
    output logic                  done,
    output logic [2:0]            status,
    output logic [ADDR_WIDTH-1:0] block_start,
    output logic [ADDR_WIDTH-1:0] block_size,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [ADDR_WIDTH-1:0] cfg_data
);
    import csa_pkg::*;

    localparam int EW = 2 + 2 * ADDR_WIDTH + TAG_WIDTH;

    // Each entry is packed as valid, hole, start, length, owner. An invalid
    // entry is a free slot of the ring and is skipped by the scan pass.
    localparam logic [EW-1:0] RESET_HEAD = {1'b1, 1'b1, {ADDR_WIDTH{1'b0}},
                                            ADDR_WIDTH'(TOTAL_MEMORY_RESET),
                                            {TAG_WIDTH{1'b0}}};

    fit_t           fit_policy_reg;
    logic           reinit;
    logic [EW-1:0]  init_head;
    logic [EW-1:0]  head;
    logic [EW-1:0]  tail;
    logic           rotate;
    ring_ctl_t      ring_ctl;
    status_t        status_w;

    // A total_memory write reloads the ring with a single hole of the new
    // size; the sequencer drops its count and next-fit position with it.
    assign reinit    = cfg_we && (reg_index_t'(cfg_index) == REG_TOTAL_MEMORY);
    assign init_head = {1'b1, 1'b1, {ADDR_WIDTH{1'b0}}, cfg_data, {TAG_WIDTH{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= FIT_FIRST;
        end
        else if (cfg_we && (reg_index_t'(cfg_index) == REG_FIT_POLICY))
        begin
            fit_policy_reg <= fit_t'(cfg_data[1:0]);
        end
    end

    always_comb
    begin
        ring_ctl.load   = reinit;
        ring_ctl.rotate = rotate;
    end

    csa_ring #(
        .DEPTH      (MAX_SEGMENTS),
        .WIDTH      (EW),
        .RESET_HEAD (RESET_HEAD)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ring_ctl),
        .init_head (init_head),
        .tail_in   (tail),
        .head_out  (head)
    );

    csa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_WIDTH   (ADDR_WIDTH),
        .TAG_WIDTH    (TAG_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .owner_tag    (owner_tag),
        .request_size (request_size),
        .policy       (fit_policy_reg),
        .reinit       (reinit),
        .head         (head),
        .tail         (tail),
        .rotate       (rotate),
        .busy         (busy),
        .done         (done),
        .status       (status_w),
        .block_start  (block_start),
        .block_size   (block_size)
    );

    assign status = status_w;

endmodule
